// File: rtl/bf7s_pkg.sv
`timescale 1ns / 1ps

package bf7s_pkg;

  localparam int PIX_W       = 8;
  localparam int PIX_MAX     = (1 << PIX_W) - 1;
  localparam int ROW_W       = 16;
  localparam int OUT_COL_W   = 10;
  localparam int CFG_WIDTH_W = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;

  localparam int DEF_RADIUS    = 3;
  localparam int DEF_MAX_WIDTH = 1024;

  localparam logic [CFG_WIDTH_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [ROW_W-1:0]       RST_HEIGHT = 16'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Output position and handling that travel with each pipeline item.
  typedef struct packed {
    logic                 emit;
    logic                 interior;
    logic                 last;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
  } pos_tag_t;

endpackage

// File: rtl/bf7s_ctrl.sv
`timescale 1ns / 1ps

module bf7s_ctrl
  import bf7s_pkg::*;
#(
  parameter int RADIUS    = DEF_RADIUS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W    = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_sel,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  flush,
  output logic                  advance,
  output logic [COL_W-1:0]      col_addr,
  output pos_tag_t              tag
);

  localparam int SPAN  = 2 * RADIUS + 1;
  localparam int WID_W = $clog2(MAX_WIDTH + 1);

  logic [CFG_WIDTH_W-1:0] width_r;
  logic [ROW_W-1:0]       height_r;
  logic [WID_W-1:0]       w_eff;
  logic [ROW_W-1:0]       h_eff;
  logic [COL_W-1:0]       w_last;
  logic [ROW_W-1:0]       h_last;

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;

  logic in_phase;
  logic col_end;
  logic out_col_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_sel)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < CFG_WIDTH_W'(SPAN)) begin
      w_eff = WID_W'(SPAN);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(width_r);
    end
    h_eff  = (height_r < ROW_W'(SPAN)) ? ROW_W'(SPAN) : height_r;
    w_last = COL_W'(w_eff - WID_W'(1));
    h_last = h_eff - ROW_W'(1);
  end

  // Once the whole image is in, the input column counter keeps running over
  // virtual positions so the line store read address keeps moving.
  assign in_phase    = in_row_r < h_eff;
  assign advance     = accept & (~in_phase | ~flush);
  assign col_end     = in_col_r == w_last;
  assign out_col_end = out_col_r == w_last;
  assign col_addr    = in_col_r;

  always_comb begin
    if (in_phase) begin
      tag.emit = (in_row_r > ROW_W'(RADIUS)) ||
                 ((in_row_r == ROW_W'(RADIUS)) && (in_col_r >= COL_W'(RADIUS)));
    end else begin
      tag.emit = 1'b1;
    end
    tag.last     = (out_row_r == h_last) && out_col_end;
    tag.interior = (out_row_r >= ROW_W'(RADIUS)) &&
                   (out_row_r < h_eff - ROW_W'(RADIUS)) &&
                   (WID_W'(out_col_r) >= WID_W'(RADIUS)) &&
                   (WID_W'(out_col_r) < w_eff - WID_W'(RADIUS));
    tag.row      = out_row_r;
    tag.col      = OUT_COL_W'(out_col_r);
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (advance) begin
      if (tag.emit && tag.last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        in_col_nxt = col_end ? '0 : in_col_r + COL_W'(1);
        if (col_end && in_phase) begin
          in_row_nxt = in_row_r + ROW_W'(1);
        end
        if (tag.emit) begin
          out_col_nxt = out_col_end ? '0 : out_col_r + COL_W'(1);
          if (out_col_end) begin
            out_row_nxt = out_row_r + ROW_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

// File: rtl/bf7s_win.sv
`timescale 1ns / 1ps

module bf7s_win
  import bf7s_pkg::*;
#(
  parameter int RADIUS    = DEF_RADIUS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W    = $clog2(MAX_WIDTH),
  localparam int SPAN     = 2 * RADIUS + 1,
  localparam int SUM_W    = $clog2(SPAN * SPAN * PIX_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [PIX_W-1:0] pixel,
  input  logic [COL_W-1:0] addr,
  input  pos_tag_t         tag_in,
  output logic             up_ready,
  input  logic             down_ready,
  output logic             win_valid,
  output logic [SUM_W-1:0] win_sum,
  output logic [PIX_W-1:0] win_center,
  output pos_tag_t         win_tag
);

  localparam int HIST_W = 2 * RADIUS * PIX_W;
  localparam int CS_W   = $clog2(SPAN * PIX_MAX + 1);

  // Each column entry holds the previous 2*RADIUS rows of that column,
  // newest row in the low byte.
  logic [HIST_W-1:0] hist_mem [MAX_WIDTH];

  logic              a_valid_r;
  logic [PIX_W-1:0]  a_pix_r;
  logic [COL_W-1:0]  a_addr_r;
  logic [HIST_W-1:0] a_hist_r;
  pos_tag_t          a_tag_r;

  logic              b_valid_r;
  logic [PIX_W-1:0]  b_center_r;
  pos_tag_t          b_tag_r;

  logic [CS_W-1:0]   col_sh_r [SPAN];
  logic [PIX_W-1:0]  ctr_sh_r [RADIUS];

  logic [PIX_W-1:0]  col_px [SPAN];
  logic [CS_W-1:0]   col_sum;
  logic [HIST_W-1:0] hist_wr;
  logic              b_ready;
  logic              a_move;

  assign b_ready  = ~b_valid_r | down_ready;
  assign a_move   = a_valid_r & b_ready;
  assign up_ready = ~a_valid_r | b_ready;

  always_comb begin
    col_px[0] = a_pix_r;
    for (int i = 0; i < 2 * RADIUS; i++) begin
      col_px[i+1] = a_hist_r[i*PIX_W +: PIX_W];
    end
    col_sum = '0;
    for (int i = 0; i < SPAN; i++) begin
      col_sum = col_sum + CS_W'(col_px[i]);
    end
  end

  assign hist_wr = {a_hist_r[HIST_W-PIX_W-1:0], a_pix_r};

  always_ff @(posedge clk) begin
    if (a_move) begin
      hist_mem[a_addr_r] <= hist_wr;
    end
    if (load) begin
      a_hist_r <= hist_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        a_valid_r <= load;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r & a_tag_r.emit;
      end
    end
  end

  // The center pixel of a column sits RADIUS rows above the newest one;
  // delayed by RADIUS items it is the pixel of the position being emitted.
  always_ff @(posedge clk) begin
    if (load) begin
      a_pix_r  <= pixel;
      a_addr_r <= addr;
      a_tag_r  <= tag_in;
    end
    if (a_move) begin
      col_sh_r[0] <= col_sum;
      for (int i = 1; i < SPAN; i++) begin
        col_sh_r[i] <= col_sh_r[i-1];
      end
      ctr_sh_r[0] <= col_px[RADIUS];
      for (int i = 1; i < RADIUS; i++) begin
        ctr_sh_r[i] <= ctr_sh_r[i-1];
      end
      b_center_r <= ctr_sh_r[RADIUS-1];
      b_tag_r    <= a_tag_r;
    end
  end

  always_comb begin
    win_sum = '0;
    for (int i = 0; i < SPAN; i++) begin
      win_sum = win_sum + SUM_W'(col_sh_r[i]);
    end
  end

  assign win_valid  = b_valid_r;
  assign win_center = b_center_r;
  assign win_tag    = b_tag_r;

endmodule

// File: rtl/bf7s_mean.sv
`timescale 1ns / 1ps

module bf7s_mean
  import bf7s_pkg::*;
#(
  parameter int RADIUS = DEF_RADIUS,
  localparam int AREA  = (2 * RADIUS + 1) * (2 * RADIUS + 1),
  localparam int SUM_W = $clog2(AREA * PIX_MAX + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 up_ready,
  input  logic [SUM_W-1:0]     in_sum,
  input  logic [PIX_W-1:0]     in_center,
  input  pos_tag_t             in_tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel,
  output logic [ROW_W-1:0]     out_row,
  output logic [OUT_COL_W-1:0] out_col,
  output logic                 out_last
);

  // Exact division by the window area: multiply by the rounded-up
  // reciprocal and keep the bits above SHIFT.
  localparam int              LOG_AREA = $clog2(AREA);
  localparam int              SHIFT    = SUM_W + LOG_AREA;
  localparam int              MULT_W   = SUM_W + 2;
  localparam int              PROD_W   = SUM_W + MULT_W;
  localparam longint unsigned RECIP    = ((64'd1 << SHIFT) + AREA - 1) / AREA;
  localparam logic [MULT_W-1:0] MULT   = MULT_W'(RECIP);

  logic              c_valid_r;
  logic [SUM_W-1:0]  c_sum_r;
  logic [PIX_W-1:0]  c_center_r;
  pos_tag_t          c_tag_r;

  logic              d_valid_r;
  logic [PROD_W-1:0] d_prod_r;
  logic [PIX_W-1:0]  d_center_r;
  pos_tag_t          d_tag_r;

  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_pixel_r;
  logic [ROW_W-1:0]     out_row_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic                 out_last_r;

  logic o_ready;
  logic d_ready;

  assign o_ready  = ~out_valid_r | out_ready;
  assign d_ready  = ~d_valid_r | o_ready;
  assign up_ready = ~c_valid_r | d_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        c_valid_r <= in_valid;
      end
      if (d_ready) begin
        d_valid_r <= c_valid_r;
      end
      if (o_ready) begin
        out_valid_r <= d_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      c_sum_r    <= in_sum;
      c_center_r <= in_center;
      c_tag_r    <= in_tag;
    end
    if (d_ready) begin
      d_prod_r   <= PROD_W'(c_sum_r) * PROD_W'(MULT);
      d_center_r <= c_center_r;
      d_tag_r    <= c_tag_r;
    end
    if (o_ready) begin
      out_pixel_r <= d_tag_r.interior ? d_prod_r[SHIFT +: PIX_W] : d_center_r;
      out_row_r   <= d_tag_r.row;
      out_col_r   <= d_tag_r.col;
      out_last_r  <= d_tag_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

endmodule

// File: rtl/box_filter_7x7_stream_core.sv
`timescale 1ns / 1ps

// Streaming box filter: takes one gray pixel per clock in raster order while
// in_ready is high and returns, also in raster order, the pixel RADIUS rows
// and RADIUS columns behind the input. Interior pixels get the truncated
// mean of the (2*RADIUS+1)-square window; pixels within RADIUS of an edge
// pass through. Unless out_ready holds it back, the block sustains one
// transfer per clock on both channels: a single column-history line store
// (MAX_WIDTH entries, one read and one write port) is read and written once
// per pixel, and every later step is a short pipeline stage. A result appears
// five register stages after its triggering transfer. After the last pixel
// of an image, send flush items (or any items) to drain the remaining RADIUS
// rows plus RADIUS pixels; flush items sent while the image is still coming
// in are consumed and do nothing. After the pixel flagged out_last the next
// item starts a new image. Writing image_width or image_height restarts the
// image; write them only while the block is idle. The line store needs no
// clearing after reset.

module box_filter_7x7_stream_core
  import bf7s_pkg::*;
#(
  parameter int RADIUS    = DEF_RADIUS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic                  in_flush,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_pixel,
  output logic [ROW_W-1:0]      out_row,
  output logic [OUT_COL_W-1:0]  out_col,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SPAN  = 2 * RADIUS + 1;
  localparam int SUM_W = $clog2(SPAN * SPAN * PIX_MAX + 1);

  logic             accept;
  logic             advance;
  logic [COL_W-1:0] col_addr;
  pos_tag_t         tag;
  cfg_reg_t         cfg_sel;

  logic             win_valid;
  logic [SUM_W-1:0] win_sum;
  logic [PIX_W-1:0] win_center;
  pos_tag_t         win_tag;
  logic             mean_ready;

  assign cfg_ready = 1'b1;
  assign cfg_sel   = cfg_reg_t'(cfg_index);
  assign accept    = in_valid & in_ready;

  bf7s_ctrl #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_sel  (cfg_sel),
    .cfg_data (cfg_data),
    .accept   (accept),
    .flush    (in_flush),
    .advance  (advance),
    .col_addr (col_addr),
    .tag      (tag)
  );

  bf7s_win #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_win (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .pixel      (in_pixel),
    .addr       (col_addr),
    .tag_in     (tag),
    .up_ready   (in_ready),
    .down_ready (mean_ready),
    .win_valid  (win_valid),
    .win_sum    (win_sum),
    .win_center (win_center),
    .win_tag    (win_tag)
  );

  bf7s_mean #(
    .RADIUS (RADIUS)
  ) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (win_valid),
    .up_ready  (mean_ready),
    .in_sum    (win_sum),
    .in_center (win_center),
    .in_tag    (win_tag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pixel (out_pixel),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (out_last)
  );

endmodule

// File: sim/box_filter_checker.sv
`timescale 1ns / 1ps

module box_filter_checker
  import bf7s_pkg::*;
#(
  parameter int RADIUS    = DEF_RADIUS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic                  in_flush,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [PIX_W-1:0]      out_pixel,
  input  logic [ROW_W-1:0]      out_row,
  input  logic [OUT_COL_W-1:0]  out_col,
  input  logic                  out_last,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending,
  output int                    fail_count
);

  localparam int SPAN = 2 * RADIUS + 1;
  localparam int AREA = SPAN * SPAN;

  typedef struct packed {
    logic [PIX_W-1:0]     pixel;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } filtered_px_t;

  logic [PIX_W-1:0]       row_history [SPAN*MAX_WIDTH];
  logic [CFG_WIDTH_W-1:0] img_width_reg;
  logic [ROW_W-1:0]       img_height_reg;
  int unsigned            feed_col, feed_row, emit_col, emit_row;
  filtered_px_t           due_pixels [$];
  int                     mismatches = 0;

  assign fail_count = mismatches;

  initial begin
    foreach (row_history[i]) row_history[i] = '0;
  end

  function automatic int unsigned used_width();
    int unsigned w;
    w = img_width_reg;
    if (w < SPAN) w = SPAN;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned used_height();
    int unsigned h;
    h = img_height_reg;
    if (h < SPAN) h = SPAN;
    return h;
  endfunction

  function automatic int unsigned history_slot(int unsigned r, int unsigned c);
    return (r % SPAN) * MAX_WIDTH + (c % MAX_WIDTH);
  endfunction

  function automatic void restart_image();
    feed_col = 0;
    feed_row = 0;
    emit_col = 0;
    emit_row = 0;
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_IMAGE_WIDTH) begin
      img_width_reg = data[CFG_WIDTH_W-1:0];
    end else begin
      img_height_reg = data[ROW_W-1:0];
    end
    restart_image();
  endfunction

  // Takes one input transfer and queues the output pixel it releases, if any.
  function automatic void filter_pixel(logic [PIX_W-1:0] pix, logic flush);
    int unsigned  w, h, fed, pos, r, c, sum;
    filtered_px_t res;
    w = used_width();
    h = used_height();
    if (feed_row < h) begin
      if (flush) return;
      row_history[history_slot(feed_row, feed_col)] = pix;
      feed_col++;
      if (feed_col >= w) begin
        feed_col = 0;
        feed_row++;
      end
      fed = feed_row * w + feed_col;
      pos = emit_row * w + emit_col;
      if (fed <= pos + RADIUS * w + RADIUS) return;
    end
    r = emit_row;
    c = emit_col;
    if (r >= RADIUS && r + RADIUS < h && c >= RADIUS && c + RADIUS < w) begin
      sum = 0;
      for (int unsigned y = r - RADIUS; y <= r + RADIUS; y++) begin
        for (int unsigned x = c - RADIUS; x <= c + RADIUS; x++) begin
          sum += row_history[history_slot(y, x)];
        end
      end
      res.pixel = PIX_W'(sum / AREA);
    end else begin
      res.pixel = row_history[history_slot(r, c)];
    end
    res.row  = ROW_W'(r);
    res.col  = OUT_COL_W'(c);
    res.last = (r == h - 1) && (c == w - 1);
    due_pixels.push_back(res);
    if (res.last) begin
      restart_image();
    end else begin
      emit_col++;
      if (emit_col >= w) begin
        emit_col = 0;
        emit_row++;
      end
    end
  endfunction

  function automatic void compare_output();
    filtered_px_t exp_px;
    if (due_pixels.size() == 0) begin
      $error("unexpected output transfer: pixel %0d row %0d col %0d last %0d",
             out_pixel, out_row, out_col, out_last);
      mismatches++;
      return;
    end
    exp_px = due_pixels.pop_front();
    if (out_pixel !== exp_px.pixel) begin
      $error("out_pixel: expected %0d, actual %0d", exp_px.pixel, out_pixel);
      mismatches++;
    end
    if (out_row !== exp_px.row) begin
      $error("out_row: expected %0d, actual %0d", exp_px.row, out_row);
      mismatches++;
    end
    if (out_col !== exp_px.col) begin
      $error("out_col: expected %0d, actual %0d", exp_px.col, out_col);
      mismatches++;
    end
    if (out_last !== exp_px.last) begin
      $error("out_last: expected %0d, actual %0d", exp_px.last, out_last);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      img_width_reg  = RST_WIDTH;
      img_height_reg = RST_HEIGHT;
      restart_image();
      due_pixels.delete();
    end else begin
      if (out_valid && out_ready) compare_output();
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) filter_pixel(in_pixel, in_flush);
    end
    pending <= due_pixels.size();
  end

endmodule

// File: sim/tb_box_filter_7x7_stream_core.sv
`timescale 1ns / 1ps

module tb_box_filter_7x7_stream_core;
  import bf7s_pkg::*;

  localparam int RADIUS       = DEF_RADIUS;
  localparam int MAX_WIDTH    = DEF_MAX_WIDTH;
  localparam int SPAN         = 2 * RADIUS + 1;
  localparam int SETTLE_CYC   = 16;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_ITEMS = 600;

  localparam int PAT_DIRECTED = 0;
  localparam int PAT_EXTREME  = 1;
  localparam int PAT_RANDOM   = 2;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel  = '0;
  logic                  in_flush  = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_pixel;
  logic [ROW_W-1:0]      out_row;
  logic [OUT_COL_W-1:0]  out_col;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          pending;
  int          fail_count;
  int unsigned cycle_cnt = 0;
  int unsigned cur_w     = RST_WIDTH;
  int unsigned cur_h     = RST_HEIGHT;
  int unsigned items_sent = 0;
  bit          in_tight  = 1'b0;
  bit          out_tight = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  box_filter_7x7_stream_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .in_flush  (in_flush),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pixel (out_pixel),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  box_filter_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel   (in_pixel),
    .in_flush   (in_flush),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pixel  (out_pixel),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_last   (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** box_filter_7x7_stream_core: FAILED **");
      $finish;
    end
  end

  function automatic int gap_draw(bit tight);
    if (tight) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(int pattern, int idx);
    if (pattern == PAT_DIRECTED) begin
      case (idx)
        0:       return '0;
        1:       return 8'h55;
        2:       return 8'hAA;
        default: return PIX_W'(PIX_MAX);
      endcase
    end
    if (pattern == PAT_EXTREME && $urandom_range(0, 2) == 0) begin
      return ($urandom_range(0, 1) == 0) ? '0 : PIX_W'(PIX_MAX);
    end
    return PIX_W'($urandom_range(0, PIX_MAX));
  endfunction

  task automatic send_item(input logic [PIX_W-1:0] pix, input logic fl);
    int gap;
    gap = gap_draw(in_tight);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    in_flush <= fl;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops the sender and waits until every queued output pixel has come out
  // and the pipeline has had time to settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic configure(input bit do_w, input logic [CFG_DATA_W-1:0] w_data,
                           input bit do_h, input logic [CFG_DATA_W-1:0] h_data);
    if (do_w) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IMAGE_WIDTH;
      cfg_data  <= w_data;
      do @(posedge clk); while (!cfg_ready);
      cur_w = w_data[CFG_WIDTH_W-1:0];
      if (cur_w < SPAN) cur_w = SPAN;
      if (cur_w > MAX_WIDTH) cur_w = MAX_WIDTH;
    end
    if (do_h) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IMAGE_HEIGHT;
      cfg_data  <= h_data;
      do @(posedge clk); while (!cfg_ready);
      cur_h = h_data;
      if (cur_h < SPAN) cur_h = SPAN;
    end
    cfg_valid <= 1'b0;
  endtask

  // Sends n_pix pixels of the current image; a complete image is followed by
  // the drain items that release the last RADIUS rows plus RADIUS pixels.
  task automatic run_image(input int n_pix, input int pattern, input int pause_at);
    bit fl;
    for (int i = 0; i < n_pix; i++) begin
      if (pattern == PAT_DIRECTED ? (i == 5) : ($urandom_range(0, 19) == 0)) begin
        send_item(PIX_W'($urandom_range(0, PIX_MAX)), 1'b1);
      end
      send_item(pick_pixel(pattern, i), 1'b0);
      items_sent++;
      if (i == pause_at) wait_idle();
    end
    if (n_pix == int'(cur_w * cur_h)) begin
      for (int j = 0; j < int'(RADIUS * cur_w + RADIUS); j++) begin
        fl = (pattern == PAT_DIRECTED) ? (j != 1) : ($urandom_range(0, 7) != 0);
        send_item(PIX_W'($urandom_range(0, PIX_MAX)), fl);
        items_sent++;
      end
    end
  endtask

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = gap_draw(out_tight);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 63) == 0) out_tight = !out_tight;
    end
  end

  initial begin
    int unsigned goal, w_val, h_val, n_img, sel;
    logic [CFG_DATA_W-1:0] w_data, h_data;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest image; a height of zero is raised to the window size. The
    // sender pauses partway until every output so far has been taken.
    configure(1'b1, 16'd7, 1'b1, 16'd0);
    run_image(int'(cur_w * cur_h), PAT_DIRECTED, 30);

    // All register bits set: width clamps to the line store, tallest image.
    // It is abandoned early, so the next write restarts mid-image.
    wait_idle();
    configure(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
    run_image(40, PAT_EXTREME, -1);

    wait_idle();
    configure(1'b1, 16'd24, 1'b1, 16'd7);
    run_image(int'(cur_w * cur_h), PAT_EXTREME, -1);

    wait_idle();
    configure(1'b1, 16'd3, 1'b1, 16'd6);
    run_image(int'(cur_w * cur_h), PAT_RANDOM, -1);

    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      wait_idle();
      in_tight = ($urandom_range(0, 3) == 0);
      w_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 24);
      h_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 12);
      w_data = {5'($urandom_range(0, 31)), 11'(w_val)};
      h_data = 16'(h_val);
      sel = $urandom_range(0, 2);
      configure(sel != 2, w_data, sel != 1, h_data);
      n_img = $urandom_range(1, 2);
      for (int k = 0; k < int'(n_img); k++) begin
        if ($urandom_range(0, 5) == 0) begin
          run_image(int'($urandom_range(1, cur_w * cur_h - 1)),
                    ($urandom_range(0, 1) == 0) ? PAT_RANDOM : PAT_EXTREME, -1);
          break;
        end
        run_image(int'(cur_w * cur_h),
                  ($urandom_range(0, 1) == 0) ? PAT_RANDOM : PAT_EXTREME, -1);
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("** box_filter_7x7_stream_core: PASSED **");
    end else begin
      $display("** box_filter_7x7_stream_core: FAILED **");
    end
    $finish;
  end

endmodule
